>>> src/msg_pkg.sv
// Shared types, constants and codes for the multi-stepper step generator.
package msg_pkg;

    localparam int NUM_STEPPERS = 8;
    localparam int SLOT_W       = 3;
    localparam int COUNT_W      = 4;
    localparam int POS_W        = 32;
    localparam int STEPS_W      = 20;
    localparam int FRAME_W      = 64;
    localparam int FRAC_W       = 3;
    localparam int IDLE_W       = 24;
    localparam int WAKE_W       = 16;
    localparam int AGG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPPERS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLEEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE            = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL           = 2'd3;

    localparam logic [COUNT_W-1:0] STEPPERS_RESET = 4'd1;
    localparam logic [IDLE_W-1:0]  IDLE_RESET     = 24'd65536;
    localparam logic [WAKE_W-1:0]  WAKE_RESET     = 16'd100;
    localparam logic [AGG_W-1:0]   DECEL_RESET    = 8'd1;

    typedef struct packed {
        logic [IDLE_W-1:0] idle_sleep_frames;
        logic [WAKE_W-1:0] wake_frames;
        logic [AGG_W-1:0]  decel_aggressiveness;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   current_position;
        logic [POS_W-1:0]   desired_position;
        logic [STEPS_W-1:0] requested_steps;
        logic               move_pending;
        logic               step_high;
        logic               moving_down;
        logic               select_one;
        logic               select_two;
        logic               is_awake;
        logic [FRAME_W-1:0] awake_at_frame;
        logic [FRAME_W-1:0] last_update_frame;
    } slot_rec_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              wr_en;
        logic              wr_set;
        logic [SLOT_W-1:0] wr_slot;
    } eng_ctl_t;

    typedef struct packed {
        logic updated;
        logic direction;
        logic step_level;
        logic ms1;
        logic ms2;
        logic awake;
    } slot_res_t;

endpackage

>>> src/multi_stepper_step_generator.sv
// Top level: stream ports, configuration registers, frame counter and slot sequencer.
// A tick visiting N slots reads, updates and writes back each slot in the slot memory,
// one result per cycle while the output is taken; the slot memory read and write-back set
// that pace. The next item is taken once a tick's last result is registered, or once a set
// target is written back. Reset clears all slot state through per-entry valid flags, with
// no clearing pass, and loads the configuration registers with defaults.
module multi_stepper_step_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // target_slot, target_steps, low_endstops, high_endstops, pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // slot, direction, step_level, ms1, ms2, awake
    output logic        m_tuser,   // updated
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [msg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msg_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SET_RD = 2'd1;
    localparam logic [1:0] S_SET_WR = 2'd2;
    localparam logic [1:0] S_TICK   = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [COUNT_W-1:0]       steppers_reg;
    cfg_t                     cfg_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic [SLOT_W-1:0]        tslot_reg;
    logic [STEPS_W-1:0]       tsteps_reg;
    logic [NUM_STEPPERS-1:0]  low_reg;
    logic [NUM_STEPPERS-1:0]  high_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       rd_idx_reg;
    logic                     ex_valid_reg;
    logic [SLOT_W-1:0]        ex_slot_reg;
    logic                     out_valid_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    slot_res_t                out_res_reg;
    logic                     out_last_reg;

    logic                     in_fire;
    logic                     ex_fire;
    logic                     rd_issue;
    logic [COUNT_W-1:0]       tick_count;
    eng_ctl_t                 ctl;
    slot_res_t                res;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    assign tick_count = (steppers_reg > COUNT_W'(NUM_STEPPERS)) ? COUNT_W'(NUM_STEPPERS)
                                                                : steppers_reg;

    assign ex_fire  = (state_reg == S_TICK) && ex_valid_reg && (!out_valid_reg || m_tready);
    assign rd_issue = (state_reg == S_TICK) && (rd_idx_reg < count_reg)
                      && (!ex_valid_reg || ex_fire);

    always_comb
    begin
        ctl.rd_en   = rd_issue || (state_reg == S_SET_RD);
        ctl.rd_slot = (state_reg == S_TICK) ? rd_idx_reg[SLOT_W-1:0] : tslot_reg;
        ctl.wr_en   = ex_fire || (state_reg == S_SET_WR);
        ctl.wr_set  = (state_reg == S_SET_WR);
        ctl.wr_slot = (state_reg == S_TICK) ? ex_slot_reg : tslot_reg;
    end

    msg_slot_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .frame        (frame_reg),
        .low_hit      (low_reg[ex_slot_reg]),
        .high_hit     (high_reg[ex_slot_reg]),
        .target_steps (tsteps_reg),
        .cfg          (cfg_reg),
        .res          (res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (s_tuser == OP_SET) ? S_SET_RD : S_TICK;
                end
            end
            S_SET_RD: state_next = S_SET_WR;
            S_SET_WR: state_next = S_IDLE;
            S_TICK:
            begin
                if (rd_idx_reg == count_reg && !ex_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steppers_reg  <= STEPPERS_RESET;
            cfg_reg       <= '{IDLE_RESET, WAKE_RESET, DECEL_RESET};
            frame_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            ex_valid_reg  <= 1'b0;
            ex_slot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEPPERS_IN_USE: steppers_reg <= cfg_data[COUNT_W-1:0];
                    CFG_IDLE_SLEEP:      cfg_reg.idle_sleep_frames <= cfg_data[IDLE_W-1:0];
                    CFG_WAKE:            cfg_reg.wake_frames <= cfg_data[WAKE_W-1:0];
                    CFG_DECEL:           cfg_reg.decel_aggressiveness <= cfg_data[AGG_W-1:0];
                    default:             steppers_reg <= steppers_reg;
                endcase
            end
            if (in_fire && s_tuser == OP_TICK)
            begin
                frame_reg  <= frame_reg + FRAME_W'(1);
                count_reg  <= tick_count;
                rd_idx_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + COUNT_W'(1);
            end
            if (rd_issue)
            begin
                ex_valid_reg <= 1'b1;
                ex_slot_reg  <= rd_idx_reg[SLOT_W-1:0];
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tslot_reg  <= s_tdata[2:0];
            tsteps_reg <= s_tdata[22:3];
            low_reg    <= s_tdata[30:23];
            high_reg   <= s_tdata[38:31];
        end
        if (ex_fire)
        begin
            out_slot_reg <= ex_slot_reg;
            out_res_reg  <= res;
            out_last_reg <= (COUNT_W'(ex_slot_reg) + COUNT_W'(1)) == count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.awake, out_res_reg.ms2, out_res_reg.ms1,
                       out_res_reg.step_level, out_res_reg.direction, out_slot_reg};
    assign m_tuser  = out_res_reg.updated;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ex_valid_reg)
        else $error("slot work in flight while accepting a new item");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_issue && ex_fire) |-> (rd_idx_reg[SLOT_W-1:0] != ex_slot_reg))
        else $error("read and write-back of the same slot in one cycle");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg |-> (COUNT_W'(ex_slot_reg) < count_reg))
        else $error("slot in flight beyond the visited count");
`endif

endmodule

>>> src/msg_step_calc.sv
// Per-slot step decision: endstops, pulse low phase, wake, idle sleep and one move.
module msg_step_calc (
    input  msg_pkg::slot_rec_t                 rec,
    input  logic [msg_pkg::FRAME_W-1:0]        frame,
    input  logic                               low_hit,
    input  logic                               high_hit,
    input  msg_pkg::cfg_t                      cfg,
    output msg_pkg::slot_rec_t                 rec_next,
    output logic                               sent
);
    import msg_pkg::*;

    logic [FRAME_W-1:0] idle_limit;
    logic [FRAME_W-1:0] wake_at;
    logic [POS_W-1:0]   reload_pos;
    logic [POS_W-1:0]   des_pos;
    logic [POS_W-1:0]   gap;
    logic [POS_W-1:0]   th_full;
    logic [POS_W-1:0]   th_half;
    logic [POS_W-1:0]   th_quarter;
    logic [FRAC_W:0]    size;
    logic               sel1;
    logic               sel2;

    assign idle_limit = rec.last_update_frame + FRAME_W'(cfg.idle_sleep_frames);
    assign wake_at    = frame + FRAME_W'(cfg.wake_frames);
    assign reload_pos = {{(POS_W-STEPS_W-FRAC_W){1'b0}}, rec.requested_steps, {FRAC_W{1'b0}}};
    assign des_pos    = (rec.current_position[FRAC_W-1:0] == '0) ? reload_pos
                                                                 : rec.desired_position;
    assign gap        = (rec.current_position > des_pos) ? rec.current_position - des_pos
                                                         : des_pos - rec.current_position;
    assign th_full    = POS_W'({cfg.decel_aggressiveness, 6'b0});
    assign th_half    = POS_W'({cfg.decel_aggressiveness, 5'b0});
    assign th_quarter = POS_W'({cfg.decel_aggressiveness, 4'b0});

    always_comb
    begin
        if (cfg.decel_aggressiveness == '0 || gap > th_full)
        begin
            size = 4'd8; sel1 = 1'b0; sel2 = 1'b0;
        end
        else if (gap > th_half)
        begin
            size = 4'd4; sel1 = 1'b1; sel2 = 1'b0;
        end
        else if (gap > th_quarter)
        begin
            size = 4'd2; sel1 = 1'b0; sel2 = 1'b1;
        end
        else
        begin
            size = 4'd1; sel1 = 1'b1; sel2 = 1'b1;
        end
    end

    always_comb
    begin
        rec_next = rec;
        sent     = 1'b0;
        if (low_hit || high_hit)
        begin
            rec_next.is_awake = 1'b0;
            sent              = 1'b1;
        end
        else if (rec.step_high)
        begin
            rec_next.step_high = 1'b0;
            sent               = 1'b1;
        end
        else if (rec.awake_at_frame > frame)
        begin
            sent = 1'b0;
        end
        else if (rec.is_awake && idle_limit < frame)
        begin
            rec_next.is_awake = 1'b0;
            sent              = 1'b1;
        end
        else if (rec.current_position == rec.desired_position && !rec.move_pending)
        begin
            sent = 1'b0;
        end
        else if (!rec.is_awake)
        begin
            rec_next.is_awake       = 1'b1;
            rec_next.awake_at_frame = wake_at;
            sent                    = 1'b1;
        end
        else
        begin
            sent                      = 1'b1;
            rec_next.desired_position = des_pos;
            if (rec.current_position != des_pos)
            begin
                rec_next.select_one = sel1;
                rec_next.select_two = sel2;
                rec_next.step_high  = 1'b1;
                if (rec.current_position < des_pos)
                begin
                    rec_next.moving_down      = 1'b0;
                    rec_next.current_position = rec.current_position + POS_W'(size);
                end
                else
                begin
                    rec_next.moving_down      = 1'b1;
                    rec_next.current_position = rec.current_position - POS_W'(size);
                end
            end
        end
        if (sent)
        begin
            rec_next.move_pending      = 1'b0;
            rec_next.last_update_frame = frame;
        end
    end

endmodule

>>> src/msg_slot_engine.sv
// Slot state memory with registered read, entry valid flags and read-modify-write datapath.
module msg_slot_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msg_pkg::eng_ctl_t             ctl,
    input  logic [msg_pkg::FRAME_W-1:0]   frame,
    input  logic                          low_hit,
    input  logic                          high_hit,
    input  logic [msg_pkg::STEPS_W-1:0]   target_steps,
    input  msg_pkg::cfg_t                 cfg,
    output msg_pkg::slot_res_t            res
);
    import msg_pkg::*;

    slot_rec_t                mem [NUM_STEPPERS];
    slot_rec_t                rd_data_reg;
    logic                     rd_ok_reg;
    logic [NUM_STEPPERS-1:0]  valid_reg;
    slot_rec_t                cur_rec;
    slot_rec_t                calc_rec;
    slot_rec_t                set_rec;
    slot_rec_t                wr_data;
    logic                     sent;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_slot] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_slot] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_ok_reg <= valid_reg[ctl.rd_slot];
            end
        end
    end

    assign cur_rec = rd_ok_reg ? rd_data_reg : '0;

    msg_step_calc u_calc (
        .rec      (cur_rec),
        .frame    (frame),
        .low_hit  (low_hit),
        .high_hit (high_hit),
        .cfg      (cfg),
        .rec_next (calc_rec),
        .sent     (sent)
    );

    always_comb
    begin
        set_rec                 = cur_rec;
        set_rec.requested_steps = target_steps;
        set_rec.move_pending    = 1'b1;
    end

    assign wr_data = ctl.wr_set ? set_rec : calc_rec;

    assign res.updated    = sent;
    assign res.direction  = sent & calc_rec.moving_down;
    assign res.step_level = sent & calc_rec.step_high;
    assign res.ms1        = sent & calc_rec.select_one;
    assign res.ms2        = sent & calc_rec.select_two;
    assign res.awake      = sent & calc_rec.is_awake;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the multi-stepper step generator stream block.
`timescale 1ns / 1ps

module tb;
    import msg_pkg::*;

    typedef struct packed {
        logic        op;
        logic [2:0]  slot;
        logic [19:0] steps;
        logic [7:0]  lo;
        logic [7:0]  hi;
    } cmd_t;

    typedef struct packed {
        logic [2:0] slot;
        logic       updated;
        logic       direction;
        logic       step_level;
        logic       ms1;
        logic       ms2;
        logic       awake;
        logic       last;
    } lines_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cmd_t   cmd_fifo[$];
    cmd_t   on_bus;
    lines_t expected_lines[$];
    bit     failed = 1'b0;
    bit     calm = 1'b0;
    int     holds_asked = 0;
    int     holds_done = 0;
    int     hold_left = 0;

    // Predictor copy of the registers and per-stepper state.
    logic [COUNT_W-1:0] slots_cfg = STEPPERS_RESET;
    logic [IDLE_W-1:0]  idle_cfg  = IDLE_RESET;
    logic [WAKE_W-1:0]  wake_cfg  = WAKE_RESET;
    logic [AGG_W-1:0]   decel_cfg = DECEL_RESET;
    bit [63:0] frame_no = '0;
    bit [31:0] pos_now[NUM_STEPPERS];
    bit [31:0] pos_goal[NUM_STEPPERS];
    bit [19:0] goal_steps[NUM_STEPPERS];
    bit        pending[NUM_STEPPERS];
    bit        pulse_hi[NUM_STEPPERS];
    bit        down_q[NUM_STEPPERS];
    bit        sel1_q[NUM_STEPPERS];
    bit        sel2_q[NUM_STEPPERS];
    bit        awake_q[NUM_STEPPERS];
    bit [63:0] wake_until[NUM_STEPPERS];
    bit [63:0] touched_at[NUM_STEPPERS];

    multi_stepper_step_generator uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic bit visit_stepper(int i, logic [7:0] lo, logic [7:0] hi);
        bit [31:0] gap;
        bit [31:0] unit;
        bit [31:0] size;
        if (lo[i] || hi[i])
        begin
            awake_q[i] = 1'b0;
            return 1'b1;
        end
        if (pulse_hi[i])
        begin
            pulse_hi[i] = 1'b0;
            return 1'b1;
        end
        if (wake_until[i] > frame_no)
            return 1'b0;
        if (awake_q[i] && (touched_at[i] + 64'(idle_cfg) < frame_no))
        begin
            awake_q[i] = 1'b0;
            return 1'b1;
        end
        if (pos_now[i] == pos_goal[i] && !pending[i])
            return 1'b0;
        if (!awake_q[i])
        begin
            awake_q[i] = 1'b1;
            wake_until[i] = frame_no + 64'(wake_cfg);
            return 1'b1;
        end
        if (pos_now[i][2:0] == 3'd0)
            pos_goal[i] = 32'(goal_steps[i]) << 3;
        if (pos_now[i] == pos_goal[i])
            return 1'b1;
        gap = (pos_now[i] > pos_goal[i]) ? pos_now[i] - pos_goal[i] : pos_goal[i] - pos_now[i];
        unit = 32'(decel_cfg) << 3;
        if (decel_cfg == '0 || gap > unit * 8)
        begin
            sel1_q[i] = 1'b0; sel2_q[i] = 1'b0; size = 8;
        end
        else if (gap > unit * 4)
        begin
            sel1_q[i] = 1'b1; sel2_q[i] = 1'b0; size = 4;
        end
        else if (gap > unit * 2)
        begin
            sel1_q[i] = 1'b0; sel2_q[i] = 1'b1; size = 2;
        end
        else
        begin
            sel1_q[i] = 1'b1; sel2_q[i] = 1'b1; size = 1;
        end
        if (pos_now[i] < pos_goal[i])
        begin
            down_q[i] = 1'b0;
            pos_now[i] = pos_now[i] + size;
        end
        else
        begin
            down_q[i] = 1'b1;
            pos_now[i] = pos_now[i] - size;
        end
        pulse_hi[i] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void predict_lines(cmd_t c);
        int     n;
        bit     sent;
        lines_t r;
        if (c.op == OP_SET)
        begin
            goal_steps[c.slot] = c.steps;
            pending[c.slot] = 1'b1;
            return;
        end
        frame_no = frame_no + 1;
        n = (slots_cfg > NUM_STEPPERS) ? NUM_STEPPERS : int'(slots_cfg);
        for (int i = 0; i < n; i++)
        begin
            sent = visit_stepper(i, c.lo, c.hi);
            r = '0;
            r.slot = 3'(i);
            r.updated = sent;
            if (sent)
            begin
                r.direction = down_q[i];
                r.step_level = pulse_hi[i];
                r.ms1 = sel1_q[i];
                r.ms2 = sel2_q[i];
                r.awake = awake_q[i];
                pending[i] = 1'b0;
                touched_at[i] = frame_no;
            end
            r.last = (i == n - 1);
            expected_lines.push_back(r);
        end
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                predict_lines(on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (cmd_fifo.size() != 0 && (calm || $urandom_range(99) >= 36))
                begin
                    on_bus = cmd_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= on_bus.op;
                    s_tdata <= {1'b0, on_bus.hi, on_bus.lo, on_bus.steps, on_bus.slot};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        lines_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_lines.size() == 0)
            begin
                $error("unexpected transfer: slot %0d", m_tdata[2:0]);
                failed = 1'b1;
            end
            else
            begin
                want = expected_lines.pop_front();
                check_field("slot", want.slot, m_tdata[2:0]);
                check_field("updated", want.updated, m_tuser);
                check_field("direction", want.direction, m_tdata[3]);
                check_field("step_level", want.step_level, m_tdata[4]);
                check_field("ms1", want.ms1, m_tdata[5]);
                check_field("ms2", want.ms2, m_tdata[6]);
                check_field("awake", want.awake, m_tdata[7]);
                check_field("last", want.last, m_tlast);
            end
        end
        if (hold_left != 0)
            hold_left = hold_left - 1;
        else if (holds_done != holds_asked)
        begin
            hold_left = 300;
            holds_done = holds_done + 1;
        end
        m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 36);
    end

    task automatic push_tick(logic [7:0] lo, logic [7:0] hi);
        cmd_t c;
        c.op = OP_TICK;
        c.slot = 3'($urandom);
        c.steps = 20'($urandom);
        c.lo = lo;
        c.hi = hi;
        cmd_fifo.push_back(c);
    endtask

    task automatic push_target(logic [2:0] slot, logic [19:0] steps);
        cmd_t c;
        c.op = OP_SET;
        c.slot = slot;
        c.steps = steps;
        c.lo = 8'($urandom);
        c.hi = 8'($urandom);
        cmd_fifo.push_back(c);
    endtask

    task automatic mixed_traffic(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 22)
            begin
                if ($urandom_range(9) == 0)
                    push_target(3'($urandom), 20'($urandom));
                else
                    push_target(3'($urandom), 20'($urandom_range(24)));
            end
            else
                push_tick(($urandom_range(19) == 0) ? 8'($urandom) : 8'h00,
                          ($urandom_range(19) == 0) ? 8'($urandom) : 8'h00);
        end
    endtask

    // Waits until every item is taken and every result checked, then lets the block settle.
    task automatic settle();
        do
            @(negedge clk);
        while (cmd_fifo.size() != 0 || s_tvalid || expected_lines.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        logic [23:0] junk;
        junk = 24'($urandom);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        case (idx)
            CFG_STEPPERS_IN_USE:
            begin
                slots_cfg = COUNT_W'(value);
                cfg_data <= {junk[23:4], slots_cfg};
            end
            CFG_IDLE_SLEEP:
            begin
                idle_cfg = IDLE_W'(value);
                cfg_data <= idle_cfg;
            end
            CFG_WAKE:
            begin
                wake_cfg = WAKE_W'(value);
                cfg_data <= {junk[23:16], wake_cfg};
            end
            default:
            begin
                decel_cfg = AGG_W'(value);
                cfg_data <= {junk[23:8], decel_cfg};
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_all(int unsigned slots, int unsigned idle, int unsigned wake,
                               int unsigned decel);
        program_reg(CFG_STEPPERS_IN_USE, slots);
        program_reg(CFG_IDLE_SLEEP, idle);
        program_reg(CFG_WAKE, wake);
        program_reg(CFG_DECEL, decel);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one slot, long wake delay, endstop while waiting.
        push_tick(8'h00, 8'h00);
        push_target(3'd0, 20'd3);
        push_tick(8'h00, 8'h00);
        push_tick(8'h00, 8'h00);
        push_tick(8'hFF, 8'h00);
        settle();

        program_all(8, 24'hFFFFFF, 0, 0);
        push_target(3'd0, 20'd0);
        push_target(3'd1, 20'hFFFFF);
        push_target(3'd7, 20'd2);
        push_target(3'd5, 20'd9);
        for (int k = 0; k < 11; k++)
        begin
            if (k == 5)
                push_tick(8'h00, 8'hFF);
            else if (k == 8)
                push_tick(8'h80, 8'h00);
            else
                push_tick(8'h00, 8'h00);
        end
        settle();

        program_all(8, $urandom_range(40, 200), 2, 1);
        calm = 1'b1;
        holds_asked = holds_asked + 1;
        mixed_traffic(50);
        settle();
        calm = 1'b0;

        program_reg(CFG_STEPPERS_IN_USE, 0);
        mixed_traffic(12);
        settle();

        program_all(15, 0, 0, 255);
        mixed_traffic(45);
        settle();

        program_all($urandom_range(1, 8), $urandom_range(60), $urandom_range(4),
                    $urandom_range(255));
        mixed_traffic(50);
        settle();

        program_all(3, 24'hFFFFFF, 16'hFFFF, 2);
        mixed_traffic(25);
        settle();

        program_all(8, 30, 1, 1);
        mixed_traffic(50);
        settle();

        if (!failed && expected_lines.size() == 0)
            $display("multi_stepper_step_generator: match");
        else
            $display("multi_stepper_step_generator: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("multi_stepper_step_generator: mismatch");
        $finish;
    end

endmodule
